[rtl/dbe_pkg.sv]
// Shared types and constants for the bilinear elevation block.
package dbe_pkg;

	// One elevation sample in metres.
	typedef logic signed [15:0] sample_t;

	// The four neighbors: (row,col), (row,col+1), (row+1,col), (row+1,col+1).
	typedef sample_t [3:0] nbr_t;

	// Sample code that marks a void post.
	localparam sample_t VOID_SAMPLE = 16'sh8000;

	// Input item kinds carried on s_tuser.
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Configuration register indexes.
	localparam logic REG_GRID_SAMPLES = 1'b0;
	localparam logic REG_TILE_VALID   = 1'b1;

	// Register width, grid minimum and reset value.
	localparam int        GRID_W     = 11;
	localparam int        GRID_MIN   = 2;
	localparam logic [10:0] GRID_RESET = 11'd1201;

	// Widths of stream fields.
	localparam int IDX_W  = 21;
	localparam int FRAC_W = 24;
	localparam int ELEV_W = 24;

	// Query sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCALE,
		ST_ROWBASE,
		ST_ADDR,
		ST_READ,
		ST_DRAIN,
		ST_CHECK,
		ST_BLEND,
		ST_OUT
	} state_t;

endpackage

[rtl/dbe_tile_mem.sv]
// Single-port tile sample memory with registered read data.
module dbe_tile_mem #(
	parameter int DEPTH  = 1442401,
	parameter int ADDR_W = 21
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [15:0]       wdata,
	output logic [15:0]       rdata
);

	logic [15:0] mem [DEPTH];

	// Write on request, read every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

[rtl/dbe_coord.sv]
// Scales one coordinate fraction by the grid span into a position and a weight.
module dbe_coord #(
	parameter int WB  = 24,
	parameter int N_W = 11
) (
	input  logic           clk,
	input  logic           en,
	input  logic [WB-1:0]  frac,
	input  logic [N_W-1:0] span,
	output logic [N_W-1:0] pos_q,
	output logic [WB-1:0]  w_q
);

	logic [WB+N_W-1:0] scaled;

	// Integer part selects the grid cell, fraction part is the weight
	assign scaled = frac * span;

	always_ff @(posedge clk) begin
		if (en) begin
			pos_q <= scaled[WB+N_W-1:WB];
			w_q   <= scaled[WB-1:0];
		end
	end

endmodule

[rtl/dbe_blend.sv]
// Bilinear blend of four samples on one shared multiply-accumulate unit.
module dbe_blend #(
	parameter int WB = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  dbe_pkg::nbr_t         p,
	input  logic [WB-1:0]         dx,
	input  logic [WB-1:0]         dy,
	output logic                  done,
	output logic [dbe_pkg::ELEV_W-1:0] elevation
);
	import dbe_pkg::*;

	localparam int S_W   = WB + 1;
	localparam int A_W   = (WB + 1 > 17) ? WB + 1 : 17;
	localparam int P_W   = A_W + S_W + 1;
	localparam int HW    = WB + 17;
	localparam int SUM_W = 2 * WB + 17;
	localparam int SH    = 2 * WB - 8;
	localparam logic [2:0] STEP_LAST = 3'd7;

	typedef struct packed {
		logic vld;
		logic clr;
		logic sh;
		logic save0;
		logic save1;
		logic last;
	} mac_ctl_t;

	logic                    busy_q;
	logic [2:0]              step_q;
	logic [S_W-1:0]          wx0, wx1, wy0, wy1;
	logic signed [A_W-1:0]   a_op;
	logic [S_W-1:0]          b_op;
	mac_ctl_t                ctl;
	mac_ctl_t                ctl_s1;
	logic signed [P_W-1:0]   prod;
	logic signed [P_W-1:0]   prod_s1;
	logic signed [SUM_W-1:0] prod_ext;
	logic signed [SUM_W-1:0] addend;
	logic signed [SUM_W-1:0] acc_sum;
	logic signed [SUM_W-1:0] acc_q;
	logic signed [SUM_W-1:0] rnd;
	logic signed [HW-1:0]    h0_q, h1_q;
	logic                    rnd_vld_s2;
	logic                    done_q;
	logic [ELEV_W-1:0]       elev_q;

	// Complementary weights
	assign wx0 = {1'b1, {WB{1'b0}}} - {1'b0, dx};
	assign wx1 = {1'b0, dx};
	assign wy0 = {1'b1, {WB{1'b0}}} - {1'b0, dy};
	assign wy1 = {1'b0, dy};

	// Step schedule: two horizontal blends, then the vertical blend split into halves
	always_comb begin
		a_op      = '0;
		b_op      = '0;
		ctl       = '0;
		ctl.vld   = busy_q;
		ctl.last  = (step_q == STEP_LAST);
		case (step_q)
			3'd0: begin
				a_op    = $signed(p[0]);
				b_op    = wx0;
				ctl.clr = 1'b1;
			end
			3'd1: begin
				a_op      = $signed(p[1]);
				b_op      = wx1;
				ctl.save0 = busy_q;
			end
			3'd2: begin
				a_op    = $signed(p[2]);
				b_op    = wx0;
				ctl.clr = 1'b1;
			end
			3'd3: begin
				a_op      = $signed(p[3]);
				b_op      = wx1;
				ctl.save1 = busy_q;
			end
			3'd4: begin
				a_op    = $signed({1'b0, h0_q[WB-1:0]});
				b_op    = wy0;
				ctl.clr = 1'b1;
			end
			3'd5: begin
				a_op   = $signed(h0_q[HW-1:WB]);
				b_op   = wy0;
				ctl.sh = 1'b1;
			end
			3'd6: begin
				a_op = $signed({1'b0, h1_q[WB-1:0]});
				b_op = wy1;
			end
			3'd7: begin
				a_op   = $signed(h1_q[HW-1:WB]);
				b_op   = wy1;
				ctl.sh = 1'b1;
			end
			default: begin
				a_op = '0;
				b_op = '0;
			end
		endcase
	end

	assign prod = a_op * $signed({1'b0, b_op});

	// Accumulate the registered product
	assign prod_ext = prod_s1;
	assign addend   = ctl_s1.sh ? (prod_ext <<< WB) : prod_ext;
	assign acc_sum  = ctl_s1.clr ? addend : acc_q + addend;

	// Round half up, keep Q.8
	assign rnd = acc_q + (SUM_W'(1) <<< (SH - 1));

	// Step counter and pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			step_q     <= '0;
			ctl_s1     <= '0;
			rnd_vld_s2 <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			ctl_s1     <= ctl;
			rnd_vld_s2 <= ctl_s1.vld & ctl_s1.last;
			done_q     <= rnd_vld_s2;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == STEP_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		if (ctl_s1.vld) begin
			acc_q <= acc_sum;
		end
		if (ctl_s1.vld && ctl_s1.save0) begin
			h0_q <= acc_sum[HW-1:0];
		end
		if (ctl_s1.vld && ctl_s1.save1) begin
			h1_q <= acc_sum[HW-1:0];
		end
		if (rnd_vld_s2) begin
			elev_q <= rnd[SH+ELEV_W-1:SH];
		end
	end

	assign done      = done_q;
	assign elevation = elev_q;

endmodule

[rtl/dem_bilinear_elevation.sv]
// Top level of the bilinear elevation block: tile memory, query sequencer and output register.
// One square tile of signed 16-bit samples (north row first) lives in a single-port
// synchronous memory of MAX_SAMPLES*MAX_SAMPLES entries; an entry must be loaded before a
// query touches it. A load request (s_tuser = 0) writes one sample (an index past the memory
// is dropped) and is taken every cycle while no query occupies the block. A query request
// (s_tuser = 1) occupies the block: scaling, address forming, four reads through the one
// memory port, then eight steps on one shared multiply-accumulate unit and a rounding stage;
// a void result skips the blend. The result sits in an output register, so the next
// request is taken while it waits. Writes to grid_samples and tile_valid are expected only
// while no query is in flight. Queries return elevation in 1/256 metre; void results carry
// elevation 0 and tuser 1.
module dem_bilinear_elevation #(
	parameter int MAX_SAMPLES = 1201,
	parameter int FRAC_BITS   = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,   // sample_index[20:0], sample_value[36:21],
	                               // lat_frac[60:37], lon_frac[84:61], zero[87:85]
	input  logic        s_tuser,   // command
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // elevation[23:0]
	output logic        m_tuser,   // void_flag
	// Configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data
);
	import dbe_pkg::*;

	localparam int WB     = (FRAC_BITS < 24) ? FRAC_BITS : 24;
	localparam int DEPTH  = MAX_SAMPLES * MAX_SAMPLES;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int N_W    = $clog2(MAX_SAMPLES + 1);

	state_t              state_q, state_d;
	logic [GRID_W-1:0]   grid_q;
	logic                valid_q;
	logic [IDX_W-1:0]    s_idx;
	logic [15:0]         s_val;
	logic [FRAC_W-1:0]   s_lat, s_lon;
	logic                in_acc;
	logic                load_we;
	logic [31:0]         g32, nsat32;
	logic [WB-1:0]       fy_q, fx_q;
	logic [N_W-1:0]      n_q, nm1_q;
	logic                scale_en;
	logic [N_W-1:0]      row, col;
	logic [WB-1:0]       dy, dx;
	logic [N_W-1:0]      rows_below;
	logic [2*N_W-1:0]    rowbase_q;
	logic [ADDR_W-1:0]   a0_q, a_row, rd_addr, mem_addr;
	logic [1:0]          rd_q;
	logic                rvld_s1;
	logic [1:0]          ridx_s1;
	logic [15:0]         rdata;
	nbr_t                p_q;
	logic                void_now, void_q;
	logic                blend_start, blend_done;
	logic [ELEV_W-1:0]   blend_elev;
	logic                out_load;
	logic                m_tvalid_q;
	logic [ELEV_W-1:0]   m_elev_q;
	logic                m_void_q;

	// Unpack the request
	assign s_idx = s_tdata[20:0];
	assign s_val = s_tdata[36:21];
	assign s_lat = s_tdata[60:37];
	assign s_lon = s_tdata[84:61];

	assign in_acc  = s_tvalid & s_tready;
	assign load_we = in_acc && (s_tuser == CMD_LOAD) && (32'(s_idx) < 32'(DEPTH));

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q  <= GRID_RESET;
			valid_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GRID_SAMPLES: grid_q  <= cfg_data;
				REG_TILE_VALID:   valid_q <= cfg_data[0];
				default:          grid_q  <= grid_q;
			endcase
		end
	end

	// Effective grid size, saturated to the supported range
	assign g32    = 32'(grid_q);
	assign nsat32 = (g32 < 32'(GRID_MIN)) ? 32'(GRID_MIN) :
	                (g32 > 32'(MAX_SAMPLES)) ? 32'(MAX_SAMPLES) : g32;

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and strobes
	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		scale_en    = 1'b0;
		blend_start = 1'b0;
		out_load    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && s_tuser == CMD_QUERY) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				scale_en = 1'b1;
				state_d  = ST_ROWBASE;
			end
			ST_ROWBASE: state_d = ST_ADDR;
			ST_ADDR:    state_d = ST_READ;
			ST_READ: begin
				if (rd_q == 2'd3) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:   state_d = ST_CHECK;
			ST_CHECK: begin
				if (void_now) begin
					state_d = ST_OUT;
				end else begin
					blend_start = 1'b1;
					state_d     = ST_BLEND;
				end
			end
			ST_BLEND: begin
				if (blend_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold query operands
	always_ff @(posedge clk) begin
		if (in_acc && s_tuser == CMD_QUERY) begin
			fy_q  <= s_lat[FRAC_W-1 -: WB];
			fx_q  <= s_lon[FRAC_W-1 -: WB];
			n_q   <= N_W'(nsat32);
			nm1_q <= N_W'(nsat32 - 32'd1);
		end
	end

	// Row and column scaling
	dbe_coord #(.WB(WB), .N_W(N_W)) u_coord_y (
		.clk   (clk),
		.en    (scale_en),
		.frac  (fy_q),
		.span  (nm1_q),
		.pos_q (row),
		.w_q   (dy)
	);

	dbe_coord #(.WB(WB), .N_W(N_W)) u_coord_x (
		.clk   (clk),
		.en    (scale_en),
		.frac  (fx_q),
		.span  (nm1_q),
		.pos_q (col),
		.w_q   (dx)
	);

	// Address of the south-west neighbor; rows count up from the south edge
	assign rows_below = nm1_q - row;

	always_ff @(posedge clk) begin
		if (state_q == ST_ROWBASE) begin
			rowbase_q <= rows_below * n_q;
		end
		if (state_q == ST_ADDR) begin
			a0_q <= ADDR_W'(rowbase_q + (2*N_W)'(col));
		end
	end

	// Neighbor addresses: next column is +1, next row north is -n
	assign a_row    = rd_q[1] ? a0_q - ADDR_W'(n_q) : a0_q;
	assign rd_addr  = a_row + ADDR_W'(rd_q[0]);
	assign mem_addr = (state_q == ST_READ) ? rd_addr : ADDR_W'(s_idx);

	dbe_tile_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_mem (
		.clk   (clk),
		.we    (load_we),
		.addr  (mem_addr),
		.wdata (s_val),
		.rdata (rdata)
	);

	// Read counter and return tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q    <= '0;
			rvld_s1 <= 1'b0;
			ridx_s1 <= '0;
		end else begin
			rvld_s1 <= (state_q == ST_READ);
			ridx_s1 <= rd_q;
			if (state_q == ST_READ) begin
				rd_q <= rd_q + 2'd1;
			end else begin
				rd_q <= '0;
			end
		end
	end

	// Capture returned neighbors
	always_ff @(posedge clk) begin
		if (rvld_s1) begin
			p_q[ridx_s1] <= rdata;
		end
	end

	// Void when the tile is unusable or any neighbor is void
	assign void_now = !valid_q || (p_q[0] == VOID_SAMPLE) || (p_q[1] == VOID_SAMPLE) ||
	                  (p_q[2] == VOID_SAMPLE) || (p_q[3] == VOID_SAMPLE);

	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			void_q <= void_now;
		end
	end

	dbe_blend #(.WB(WB)) u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (blend_start),
		.p         (p_q),
		.dx        (dx),
		.dy        (dy),
		.done      (blend_done),
		.elevation (blend_elev)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_elev_q <= void_q ? '0 : blend_elev;
			m_void_q <= void_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_elev_q;
	assign m_tuser  = m_void_q;

endmodule
